@@ rtl/pbe_pkg.sv @@
`default_nettype none

package pbe_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PIECE_DEF = 127;
  localparam int OUT_LANES_DEF = 4;

  // Lanes carried by one result word
  localparam int MAX_LANES  = 4;
  localparam int LANE_IDX_W = 2;
  localparam int BCNT_W     = 3;

  // Segment length counter: literal fill or pending run length (up to 127)
  localparam int CNT_W = 7;

  // Depth of the command queue between the front and back parts
  localparam int CMD_DEPTH = 4;

  // Command kinds
  localparam logic [1:0] CMD_LIT = 2'd0;  // header 256-len, then store[0..len-1]
  localparam logic [1:0] CMD_RUN = 2'd1;  // len, then value
  localparam logic [1:0] CMD_END = 2'd2;  // close the burst of one input word

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_byte_0;
    logic [7:0]        out_byte_1;
    logic [7:0]        out_byte_2;
    logic [7:0]        out_byte_3;
    logic [BCNT_W-1:0] byte_count;
    logic              burst_last;
    logic              stream_done;
  } out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] len;
    logic [7:0]       value;
    logic             eos;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/pbe_ram.sv @@
`default_nettype none

module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbe_cmd_fifo.sv @@
`default_nettype none

module pbe_cmd_fifo
  import pbe_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   fill_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (fill_r == CW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbe_front.sv @@
`default_nettype none

module pbe_front
  import pbe_pkg::*;
#(
  parameter int MAX_PIECE = MAX_PIECE_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  input  wire logic q_full,
  output logic      cmd_push,
  output cmd_t      cmd,
  output logic      st_we,
  output logic [((MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1)-1:0] st_waddr,
  output logic [7:0] st_wdata,
  input  wire logic flush_done,
  output logic      lit_busy
);

  localparam int AW = (MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1;
  localparam logic [CNT_W-1:0] PIECE = CNT_W'(MAX_PIECE);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_G1   = 3'd1;
  localparam logic [2:0] PH_G2   = 3'd2;
  localparam logic [2:0] PH_EOS  = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  localparam logic MODE_LIT = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  logic [2:0]       phase_r,      phase_nxt;
  logic [7:0]       held_byte_r,  held_byte_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic             mode_r,       mode_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic             eos_r,        eos_nxt;
  logic             emitted_r,    emitted_nxt;
  logic             lit_busy_r;
  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic             at_limit;
  logic [7:0]       b;

  assign in_full  = (phase_r != PH_IDLE) || q_full || lit_busy_r;
  assign accept   = in_push && !in_full;
  assign lit_busy = lit_busy_r;
  assign b        = in_data.data_byte;
  assign cnt_inc  = count_r + 1'b1;
  assign at_limit = (cnt_inc >= PIECE);
  assign st_waddr = count_r[AW-1:0];
  assign st_wdata = held_byte_r;

  // Classify the word and sequence the commands it causes
  always_comb begin
    phase_nxt      = phase_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    eos_nxt        = eos_r;
    emitted_nxt    = emitted_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    st_we          = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          eos_nxt = in_data.end_of_stream;
          if (!held_valid_r) begin
            held_byte_nxt  = b;
            held_valid_nxt = 1'b1;
            mode_nxt       = MODE_LIT;
            count_nxt      = '0;
          end else if (mode_r == MODE_LIT && b == held_byte_r) begin
            // a pair starts a run: flush pending literal first
            if (count_r != '0) begin
              cmd_push = 1'b1;
              cmd.kind = CMD_LIT;
              cmd.len  = count_r;
            end
            mode_nxt  = MODE_RUN;
            count_nxt = '0;
          end else if (mode_r == MODE_LIT) begin
            // commit the held byte to the literal
            st_we = 1'b1;
            if (at_limit) begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_LIT;
              cmd.len   = cnt_inc;
              count_nxt = '0;
            end else begin
              count_nxt = cnt_inc;
            end
            held_byte_nxt = b;
          end else if (b == held_byte_r) begin
            // grow the run
            if (at_limit) begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_RUN;
              cmd.len   = cnt_inc;
              cmd.value = held_byte_r;
              count_nxt = '0;
            end else begin
              count_nxt = cnt_inc;
            end
          end else begin
            // run broken: send what remains of it
            if (count_r != '0) begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_RUN;
              cmd.len   = count_r;
              cmd.value = held_byte_r;
            end
            mode_nxt      = MODE_LIT;
            count_nxt     = '0;
            held_byte_nxt = b;
          end
          emitted_nxt = cmd_push;
          if (held_valid_r && mode_r == MODE_LIT && b == held_byte_r) begin
            phase_nxt = PH_G1;
          end else if (in_data.end_of_stream) begin
            phase_nxt = PH_EOS;
          end else if (cmd_push) begin
            phase_nxt = PH_END;
          end
        end
      end
      PH_G1, PH_G2: begin
        // count the two bytes of the opening pair
        if (!q_full) begin
          if (at_limit) begin
            cmd_push  = 1'b1;
            cmd.kind  = CMD_RUN;
            cmd.len   = cnt_inc;
            cmd.value = held_byte_r;
            count_nxt = '0;
          end else begin
            count_nxt = cnt_inc;
          end
          emitted_nxt = emitted_r || cmd_push;
          if (phase_r == PH_G1) begin
            phase_nxt = PH_G2;
          end else if (eos_r) begin
            phase_nxt = PH_EOS;
          end else if (emitted_nxt) begin
            phase_nxt = PH_END;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_EOS: begin
        // flush everything pending and clear the segment state
        if (!q_full && !lit_busy_r) begin
          if (mode_r == MODE_RUN) begin
            if (count_r != '0) begin
              cmd_push  = 1'b1;
              cmd.kind  = CMD_RUN;
              cmd.len   = count_r;
              cmd.value = held_byte_r;
            end
          end else begin
            st_we    = 1'b1;
            cmd_push = 1'b1;
            cmd.kind = CMD_LIT;
            cmd.len  = cnt_inc;
          end
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          mode_nxt       = MODE_LIT;
          count_nxt      = '0;
          emitted_nxt    = emitted_r || cmd_push;
          phase_nxt      = emitted_nxt ? PH_END : PH_IDLE;
        end
      end
      PH_END: begin
        // close the burst so the back part marks its last word
        if (!q_full) begin
          cmd_push    = 1'b1;
          cmd.kind    = CMD_END;
          cmd.eos     = eos_r;
          emitted_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Hold segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      mode_r       <= MODE_LIT;
      count_r      <= '0;
      eos_r        <= 1'b0;
      emitted_r    <= 1'b0;
      lit_busy_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      eos_r        <= eos_nxt;
      emitted_r    <= emitted_nxt;
      // the store is owned by the back part while a literal is read out
      if (cmd_push && cmd.kind == CMD_LIT) begin
        lit_busy_r <= 1'b1;
      end else if (flush_done) begin
        lit_busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbe_back.sv @@
`default_nettype none

module pbe_back
  import pbe_pkg::*;
#(
  parameter int MAX_PIECE = MAX_PIECE_DEF,
  parameter int OUT_LANES = OUT_LANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      rd_en,
  output logic [((MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1)-1:0] rd_addr,
  input  wire logic [7:0] rd_data,
  output logic      flush_done,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  localparam int AW    = (MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1;
  localparam int LANES = (OUT_LANES > MAX_LANES) ? MAX_LANES :
                         ((OUT_LANES < 1) ? 1 : OUT_LANES);
  localparam logic [BCNT_W-1:0] ACC_FULL = BCNT_W'(LANES);

  localparam logic [2:0] BS_IDLE     = 3'd0;
  localparam logic [2:0] BS_RUN_LEN  = 3'd1;
  localparam logic [2:0] BS_RUN_VAL  = 3'd2;
  localparam logic [2:0] BS_LIT_HDR  = 3'd3;
  localparam logic [2:0] BS_LIT_DATA = 3'd4;

  logic [2:0]       bst_r, bst_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [7:0]       val_r, val_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic [MAX_LANES-1:0][7:0] acc_r,     acc_nxt;
  logic [BCNT_W-1:0]         acc_cnt_r, acc_cnt_nxt;
  out_t                      out_r;
  logic                      out_valid_r;
  out_t                      word;
  logic                      out_load;
  logic                      out_free;
  logic                      byte_ok;
  logic                      end_ok;
  logic                      byte_vld;
  logic                      byte_fire;
  logic [7:0]                byte_val;
  logic                      end_fire;

  assign out_free  = !out_valid_r || out_pop;
  assign byte_ok   = (acc_cnt_r != ACC_FULL) || out_free;
  assign end_ok    = (acc_cnt_r == '0) || out_free;
  assign byte_fire = byte_vld && byte_ok;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // Expand commands into encoded bytes, one per cycle unless the accumulator is full and the result is not taken
  always_comb begin
    bst_nxt    = bst_r;
    len_nxt    = len_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    cmd_pop    = 1'b0;
    byte_vld   = 1'b0;
    byte_val   = rd_data;
    end_fire   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    flush_done = 1'b0;
    case (bst_r)
      BS_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.kind)
            CMD_END: begin
              if (end_ok) begin
                cmd_pop  = 1'b1;
                end_fire = 1'b1;
              end
            end
            CMD_RUN: begin
              cmd_pop = 1'b1;
              len_nxt = cmd.len;
              val_nxt = cmd.value;
              bst_nxt = BS_RUN_LEN;
            end
            CMD_LIT: begin
              cmd_pop = 1'b1;
              len_nxt = cmd.len;
              idx_nxt = CNT_W'(1);
              bst_nxt = BS_LIT_HDR;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BS_RUN_LEN: begin
        byte_vld = 1'b1;
        byte_val = {1'b0, len_r};
        if (byte_ok) begin
          bst_nxt = BS_RUN_VAL;
        end
      end
      BS_RUN_VAL: begin
        byte_vld = 1'b1;
        byte_val = val_r;
        if (byte_ok) begin
          bst_nxt = BS_IDLE;
        end
      end
      BS_LIT_HDR: begin
        // header is 256 - length, taken mod 256
        byte_vld = 1'b1;
        byte_val = 8'd0 - {1'b0, len_r};
        if (byte_ok) begin
          rd_en   = 1'b1;
          bst_nxt = BS_LIT_DATA;
        end
      end
      BS_LIT_DATA: begin
        byte_vld = 1'b1;
        byte_val = rd_data;
        if (byte_ok) begin
          if (idx_r == len_r) begin
            flush_done = 1'b1;
            bst_nxt    = BS_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r[AW-1:0];
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        bst_nxt = BS_IDLE;
      end
    endcase
  end

  // Pack bytes into lanes; a full word waits until the next byte or the burst end
  always_comb begin
    acc_nxt          = acc_r;
    acc_cnt_nxt      = acc_cnt_r;
    out_load         = 1'b0;
    word.out_byte_0  = acc_r[0];
    word.out_byte_1  = acc_r[1];
    word.out_byte_2  = acc_r[2];
    word.out_byte_3  = acc_r[3];
    word.byte_count  = acc_cnt_r;
    word.burst_last  = 1'b0;
    word.stream_done = 1'b0;
    if (byte_fire) begin
      if (acc_cnt_r == ACC_FULL) begin
        out_load    = 1'b1;
        acc_nxt     = '0;
        acc_nxt[0]  = byte_val;
        acc_cnt_nxt = BCNT_W'(1);
      end else begin
        acc_nxt[acc_cnt_r[LANE_IDX_W-1:0]] = byte_val;
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end
    end else if (end_fire && acc_cnt_r != '0) begin
      out_load         = 1'b1;
      word.burst_last  = 1'b1;
      word.stream_done = cmd.eos;
      acc_nxt          = '0;
      acc_cnt_nxt      = '0;
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r <= BS_IDLE;
    end else begin
      bst_r <= bst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    val_r <= val_nxt;
    idx_r <= idx_nxt;
  end

  // Hold the lane accumulator and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/packbits_rle_encoder_unit.sv @@
// PackBits-style run-length encoder, one raw byte per input word.
// Input channel: a word {data_byte, end_of_stream} is taken when in_push is
// high and in_full is low. Result channel: while out_empty is low, out_data
// holds the oldest result; out_pop takes it. Each result packs up to four
// encoded bytes from lane 0, with byte_count, burst_last on the final word
// of one input's burst and stream_done on the final word of the stream.
// A front part classifies each byte (literal, run start, run growth) and
// writes literal bytes to a store; a four-entry command queue feeds a back
// part that expands commands into bytes, one byte per cycle unless the
// accumulator is full and the result is not taken, and packs them. A byte
// that extends a literal or a run passes through no extra phase. A run start
// passes through phases G1 and G2, and an end-of-stream byte through EOS to
// flush. A byte that causes output adds an END phase to close its burst, and
// while a literal is read out of the store new input is held off.
// Reset (rst_n low, synchronous) empties the queue and the result register
// and starts a fresh stream; the store needs no clearing. When the receiver
// stalls, results back up into the accumulator and queue, then in_full rises.
`default_nettype none

module packbits_rle_encoder_unit
  import pbe_pkg::*;
#(
  parameter int MAX_PIECE = MAX_PIECE_DEF,
  parameter int OUT_LANES = OUT_LANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  localparam int AW = (MAX_PIECE > 1) ? $clog2(MAX_PIECE) : 1;

  logic          cmd_push;
  cmd_t          cmd_in;
  logic          cmd_full;
  logic          cmd_pop;
  cmd_t          cmd_out;
  logic          cmd_empty;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          flush_done;
  logic          lit_busy;

  pbe_front #(
    .MAX_PIECE (MAX_PIECE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .q_full     (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .flush_done (flush_done),
    .lit_busy   (lit_busy)
  );

  pbe_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  pbe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PIECE)
  ) u_lit_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pbe_back #(
    .MAX_PIECE (MAX_PIECE),
    .OUT_LANES (OUT_LANES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .flush_done (flush_done),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  // The store is never written while a literal is being read out
  a_store_owned: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> !lit_busy)
    else $error("literal store written during read-out");

  // The front never pushes into a full command queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // A result word carries one to four bytes
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.byte_count != '0 && out_data.byte_count <= 3'd4))
    else $error("byte count out of range");

  // The end of a stream is always the end of a burst
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.stream_done) |-> out_data.burst_last)
    else $error("stream_done without burst_last");
`endif

endmodule

`default_nettype wire
